/* hdl/pfm_pkg.sv */
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared types and constants for the page-fault frame manager.
// ----------------------------------------------------------------------------
package pfm_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FRAME_BITS = $clog2(MAX_FRAMES);
	localparam int CNT_W      = FRAME_BITS + 1;
	localparam int PAGE_BITS  = 16;
	localparam int PICK_BITS  = 16;
	localparam int CTR_W      = 32;
	localparam int CFG_W      = 7;
	localparam int STEP_W     = $clog2(PICK_BITS + 1);
	localparam int IDX_PAD    = PICK_BITS - CNT_W;

	localparam logic [STEP_W-1:0] DIV_FULL_STEPS = STEP_W'(PICK_BITS);
	localparam logic [STEP_W-1:0] DIV_IDX_STEPS  = STEP_W'(CNT_W);

	localparam logic [1:0] ACC_ABSENT  = 2'd0;
	localparam logic [1:0] ACC_READ    = 2'd1;
	localparam logic [1:0] ACC_INVALID = 2'd2;
	localparam logic [1:0] ACC_RW      = 2'd3;

	localparam logic [1:0] ST_FREE    = 2'd0;
	localparam logic [1:0] ST_EVICT   = 2'd1;
	localparam logic [1:0] ST_UPGRADE = 2'd2;
	localparam logic [1:0] ST_ERROR   = 2'd3;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	localparam logic POLICY_RANDOM = 1'b0;
	localparam logic POLICY_FIFO   = 1'b1;

	typedef struct packed {
		logic                 start;
		logic [PICK_BITS-1:0] dividend;
		logic [STEP_W-1:0]    steps;
	} div_req_t;

endpackage

/* hdl/pfm_mod_unit.sv */
// ----------------------------------------------------------------------------
// pfm_mod_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pfm_mod_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfm_pkg::div_req_t              req,
	input  logic [pfm_pkg::CNT_W-1:0]      divisor,
	output logic                           done,
	output logic [pfm_pkg::FRAME_BITS-1:0] remainder
);

	logic [pfm_pkg::CNT_W-1:0]     rem_q;
	logic [pfm_pkg::PICK_BITS-1:0] dvd_q;
	logic [pfm_pkg::STEP_W-1:0]    cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pfm_pkg::CNT_W-1:0]     trial;

	assign trial = {rem_q[pfm_pkg::CNT_W-2:0], dvd_q[pfm_pkg::PICK_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - pfm_pkg::STEP_W'(1);
				if (cnt_q == pfm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pfm_pkg::PICK_BITS-2:0], 1'b0};
			rem_q <= (trial >= divisor) ? trial - divisor : trial;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[pfm_pkg::FRAME_BITS-1:0];

endmodule

/* hdl/page_fault_frame_manager.sv */
// ----------------------------------------------------------------------------
// page_fault_frame_manager
// Page-fault handler: write upgrade, free-frame allocation, FIFO or random
// eviction with write-back flagging, and running fault/read/write counters.
// ----------------------------------------------------------------------------
// One fault transaction is handled at a time; in_ready is high only while the
// sequencer is idle, and a finished result may wait in the output register
// while the next fault is taken. A page load scans the frame table one frame
// per cycle, up to 64 frames, and an eviction adds the victim lookup plus the
// shared remainder unit, used for the random pick modulo the frame count and
// for each ring index update; a stalled result holds the sequencer until the
// output register is free.
// Frame state is cleared by reset at once; no clearing pass is needed.
module page_fault_frame_manager (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [pfm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pfm_pkg::PAGE_BITS-1:0]  fault_page,
	input  logic [1:0]                     entry_access,
	input  logic [pfm_pkg::FRAME_BITS-1:0] entry_frame,
	input  logic [pfm_pkg::PICK_BITS-1:0]  random_pick,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfm_pkg::FRAME_BITS-1:0] target_frame,
	output logic [1:0]                     new_access,
	output logic [1:0]                     fault_status,
	output logic                           victim_valid,
	output logic [pfm_pkg::PAGE_BITS-1:0]  victim_page,
	output logic                           victim_writeback,
	output logic                           fetch_from_disk,
	output logic [pfm_pkg::CTR_W-1:0]      fault_total,
	output logic [pfm_pkg::CTR_W-1:0]      read_total,
	output logic [pfm_pkg::CTR_W-1:0]      write_total
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_PICK, S_RING, S_VIC_RD, S_VIC, S_HEAD, S_LOAD, S_TAIL,
		S_COMMIT, S_DONE
	} state_t;

	localparam int FB = pfm_pkg::FRAME_BITS;
	localparam int CW = pfm_pkg::CNT_W;

	state_t state_q;

	logic                           policy_q;
	logic [pfm_pkg::CFG_W-1:0]      fiu_q;
	logic [CW-1:0]                  n_q;
	logic [pfm_pkg::PAGE_BITS-1:0]  page_q;
	logic [pfm_pkg::PICK_BITS-1:0]  pick_q;
	logic [FB-1:0]                  chk_q;
	logic [FB-1:0]                  target_q;
	logic [1:0]                     new_acc_q;
	logic [1:0]                     status_q;
	logic                           vvalid_q;
	logic [pfm_pkg::PAGE_BITS-1:0]  vpage_q;
	logic                           vwb_q;
	logic                           fetch_q;
	logic [FB-1:0]                  head_q;
	logic [FB-1:0]                  tail_q;
	logic [pfm_pkg::CTR_W-1:0]      faults_q;
	logic [pfm_pkg::CTR_W-1:0]      reads_q;
	logic [pfm_pkg::CTR_W-1:0]      writes_q;

	logic                           out_valid_q;
	logic [FB-1:0]                  o_target_q;
	logic [1:0]                     o_acc_q;
	logic [1:0]                     o_status_q;
	logic                           o_vvalid_q;
	logic [pfm_pkg::PAGE_BITS-1:0]  o_vpage_q;
	logic                           o_vwb_q;
	logic                           o_fetch_q;
	logic [pfm_pkg::CTR_W-1:0]      o_faults_q;
	logic [pfm_pkg::CTR_W-1:0]      o_reads_q;
	logic [pfm_pkg::CTR_W-1:0]      o_writes_q;

	logic [pfm_pkg::PAGE_BITS-1:0]  owner_mem [pfm_pkg::MAX_FRAMES];
	logic [1:0]                     acc_mem   [pfm_pkg::MAX_FRAMES];
	logic [FB-1:0]                  ring_mem  [pfm_pkg::MAX_FRAMES];
	logic [pfm_pkg::MAX_FRAMES-1:0] acc_vld_q;

	logic [pfm_pkg::PAGE_BITS-1:0]  owner_rd_q;
	logic [1:0]                     acc_rd_q;
	logic                           acc_rdv_q;
	logic [FB-1:0]                  ring_rd_q;

	logic [FB-1:0]                  rd_addr;
	logic [1:0]                     acc_data;
	logic [CW-1:0]                  frame_n;
	logic [CW-1:0]                  n_last;
	logic [CW-1:0]                  head_inc;
	logic [CW-1:0]                  tail_inc;
	logic                           commit_we;
	logic                           ring_we;
	logic                           out_free;
	pfm_pkg::div_req_t              div_req;
	logic                           div_done;
	logic [FB-1:0]                  div_rem;

	pfm_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.divisor   (n_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		if (fiu_q == '0) begin
			frame_n = CW'(1);
		end else if (fiu_q > pfm_pkg::CFG_W'(pfm_pkg::MAX_FRAMES)) begin
			frame_n = CW'(pfm_pkg::MAX_FRAMES);
		end else begin
			frame_n = CW'(fiu_q);
		end
	end

	assign n_last    = n_q - CW'(1);
	assign head_inc  = {1'b0, head_q} + CW'(1);
	assign tail_inc  = {1'b0, tail_q} + CW'(1);
	assign acc_data  = acc_rdv_q ? acc_rd_q : pfm_pkg::ACC_ABSENT;
	assign commit_we = (state_q == S_COMMIT);
	assign ring_we   = (state_q == S_LOAD) && (policy_q == pfm_pkg::POLICY_FIFO);
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = '0;
			S_SCAN:  rd_addr = chk_q + FB'(1);
			default: rd_addr = target_q;
		endcase
	end

	always_comb begin
		div_req = '0;
		if (state_q == S_SCAN && acc_data != pfm_pkg::ACC_ABSENT
				&& {1'b0, chk_q} == n_last && policy_q == pfm_pkg::POLICY_RANDOM) begin
			div_req.start    = 1'b1;
			div_req.dividend = pick_q;
			div_req.steps    = pfm_pkg::DIV_FULL_STEPS;
		end else if (state_q == S_VIC) begin
			div_req.start    = 1'b1;
			div_req.dividend = {head_inc, pfm_pkg::IDX_PAD'(0)};
			div_req.steps    = pfm_pkg::DIV_IDX_STEPS;
		end else if (ring_we) begin
			div_req.start    = 1'b1;
			div_req.dividend = {tail_inc, pfm_pkg::IDX_PAD'(0)};
			div_req.steps    = pfm_pkg::DIV_IDX_STEPS;
		end
	end

	always_ff @(posedge clk) begin
		acc_rd_q   <= acc_mem[rd_addr];
		owner_rd_q <= owner_mem[target_q];
		ring_rd_q  <= ring_mem[head_q];
		if (commit_we) begin
			acc_mem[target_q]   <= new_acc_q;
			owner_mem[target_q] <= page_q;
		end
		if (ring_we) begin
			ring_mem[tail_q] <= target_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			acc_rdv_q <= 1'b0;
		end else begin
			acc_rdv_q <= acc_vld_q[rd_addr];
			if (commit_we) begin
				acc_vld_q[target_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= pfm_pkg::POLICY_FIFO;
			fiu_q       <= pfm_pkg::CFG_W'(pfm_pkg::MAX_FRAMES);
			head_q      <= '0;
			tail_q      <= '0;
			faults_q    <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfm_pkg::REG_POLICY: policy_q <= cfg_data[0];
					pfm_pkg::REG_FRAMES: fiu_q    <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						page_q    <= fault_page;
						pick_q    <= random_pick;
						n_q       <= frame_n;
						faults_q  <= faults_q + pfm_pkg::CTR_W'(1);
						chk_q     <= '0;
						target_q  <= '0;
						new_acc_q <= pfm_pkg::ACC_ABSENT;
						status_q  <= pfm_pkg::ST_ERROR;
						vvalid_q  <= 1'b0;
						vpage_q   <= '0;
						vwb_q     <= 1'b0;
						fetch_q   <= 1'b0;
						case (entry_access) inside
							pfm_pkg::ACC_ABSENT: state_q <= S_SCAN;
							pfm_pkg::ACC_READ, pfm_pkg::ACC_RW: begin
								if ({1'b0, entry_frame} < frame_n) begin
									target_q  <= entry_frame;
									new_acc_q <= pfm_pkg::ACC_RW;
									status_q  <= pfm_pkg::ST_UPGRADE;
									state_q   <= S_COMMIT;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (acc_data == pfm_pkg::ACC_ABSENT) begin
						target_q <= chk_q;
						status_q <= pfm_pkg::ST_FREE;
						state_q  <= S_LOAD;
					end else if ({1'b0, chk_q} == n_last) begin
						if (policy_q == pfm_pkg::POLICY_RANDOM) begin
							state_q <= S_PICK;
						end else if (head_q == tail_q) begin
							state_q <= S_RING;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						chk_q <= chk_q + FB'(1);
					end
				end
				S_PICK: begin
					if (div_done) begin
						target_q <= div_rem;
						state_q  <= S_VIC_RD;
					end
				end
				S_RING: begin
					target_q <= ring_rd_q;
					state_q  <= S_VIC_RD;
				end
				S_VIC_RD: state_q <= S_VIC;
				S_VIC: begin
					vvalid_q <= 1'b1;
					vpage_q  <= owner_rd_q;
					status_q <= pfm_pkg::ST_EVICT;
					if (acc_data[1]) begin
						vwb_q    <= 1'b1;
						writes_q <= writes_q + pfm_pkg::CTR_W'(1);
					end
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					if (div_done) begin
						head_q  <= div_rem;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					new_acc_q <= pfm_pkg::ACC_READ;
					fetch_q   <= 1'b1;
					reads_q   <= reads_q + pfm_pkg::CTR_W'(1);
					state_q   <= ring_we ? S_TAIL : S_COMMIT;
				end
				S_TAIL: begin
					if (div_done) begin
						tail_q  <= div_rem;
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						o_target_q  <= target_q;
						o_acc_q     <= new_acc_q;
						o_status_q  <= status_q;
						o_vvalid_q  <= vvalid_q;
						o_vpage_q   <= vpage_q;
						o_vwb_q     <= vwb_q;
						o_fetch_q   <= fetch_q;
						o_faults_q  <= faults_q;
						o_reads_q   <= reads_q;
						o_writes_q  <= writes_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign target_frame     = o_target_q;
	assign new_access       = o_acc_q;
	assign fault_status     = o_status_q;
	assign victim_valid     = o_vvalid_q;
	assign victim_page      = o_vpage_q;
	assign victim_writeback = o_vwb_q;
	assign fetch_from_disk  = o_fetch_q;
	assign fault_total      = o_faults_q;
	assign read_total       = o_reads_q;
	assign write_total      = o_writes_q;

endmodule

/* hdl/pfm_checker.sv */
// ----------------------------------------------------------------------------
// pfm_checker
// Port-level checks for the page-fault frame manager, bound to the top level.
// ----------------------------------------------------------------------------
module pfm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [pfm_pkg::FRAME_BITS-1:0] target_frame,
	input logic [1:0]                     new_access,
	input logic [1:0]                     fault_status,
	input logic                           victim_valid,
	input logic [pfm_pkg::PAGE_BITS-1:0]  victim_page,
	input logic                           victim_writeback,
	input logic                           fetch_from_disk
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target_frame)
			&& $stable(fault_status) && $stable(victim_page))
		else $error("result changed while stalled");

	// one transaction in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transaction");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_status == pfm_pkg::ST_ERROR |-> target_frame == '0
			&& new_access == pfm_pkg::ACC_ABSENT && !victim_valid && !fetch_from_disk)
		else $error("error result carries data");

	a_no_victim_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !victim_valid |-> victim_page == '0 && !victim_writeback)
		else $error("victim fields set without a victim");

	a_load_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_status == pfm_pkg::ST_FREE || fault_status == pfm_pkg::ST_EVICT)
			|-> fetch_from_disk && new_access == pfm_pkg::ACC_READ)
		else $error("page load without disk fetch");

endmodule

bind page_fault_frame_manager pfm_checker u_pfm_checker (.*);

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page-fault frame manager. A behavioral frame
// table predicts every fault result; results are checked field by field in
// arrival order. Covers loads into free frames, FIFO and random eviction with
// write-back flagging, upgrades, errors and out-of-range frame counts, with
// random gaps on the fault side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [pfm_pkg::PAGE_BITS-1:0]  page;
		logic [1:0]                     access;
		logic [pfm_pkg::FRAME_BITS-1:0] frame;
		logic [pfm_pkg::PICK_BITS-1:0]  pick;
	} fault_t;

	typedef struct packed {
		logic [pfm_pkg::FRAME_BITS-1:0] frame;
		logic [1:0]                     access;
		logic [1:0]                     status;
		logic                           vvalid;
		logic [pfm_pkg::PAGE_BITS-1:0]  vpage;
		logic                           vwb;
		logic                           fetch;
		logic [pfm_pkg::CTR_W-1:0]      faults;
		logic [pfm_pkg::CTR_W-1:0]      reads;
		logic [pfm_pkg::CTR_W-1:0]      writes;
	} result_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic                           cfg_index = pfm_pkg::REG_POLICY;
	logic [pfm_pkg::CFG_W-1:0]      cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [pfm_pkg::PAGE_BITS-1:0]  fault_page = '0;
	logic [1:0]                     entry_access = pfm_pkg::ACC_ABSENT;
	logic [pfm_pkg::FRAME_BITS-1:0] entry_frame = '0;
	logic [pfm_pkg::PICK_BITS-1:0]  random_pick = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [pfm_pkg::FRAME_BITS-1:0] target_frame;
	logic [1:0]                     new_access;
	logic [1:0]                     fault_status;
	logic                           victim_valid;
	logic [pfm_pkg::PAGE_BITS-1:0]  victim_page;
	logic                           victim_writeback;
	logic                           fetch_from_disk;
	logic [pfm_pkg::CTR_W-1:0]      fault_total;
	logic [pfm_pkg::CTR_W-1:0]      read_total;
	logic [pfm_pkg::CTR_W-1:0]      write_total;

	page_fault_frame_manager DUT (.*);

	// frame table mirror
	logic                           policy = pfm_pkg::POLICY_FIFO;
	logic [pfm_pkg::CFG_W-1:0]      frames_reg = 7'd64;
	logic [pfm_pkg::PAGE_BITS-1:0]  owner [pfm_pkg::MAX_FRAMES];
	logic [1:0]                     frame_acc [pfm_pkg::MAX_FRAMES] =
		'{default: pfm_pkg::ACC_ABSENT};
	logic [pfm_pkg::FRAME_BITS-1:0] load_ring [pfm_pkg::MAX_FRAMES];
	logic [pfm_pkg::MAX_FRAMES-1:0] ring_loaded = '0;
	logic [pfm_pkg::FRAME_BITS-1:0] ring_head = '0;
	logic [pfm_pkg::FRAME_BITS-1:0] ring_tail = '0;
	logic [pfm_pkg::CTR_W-1:0]      n_faults = '0;
	logic [pfm_pkg::CTR_W-1:0]      n_reads = '0;
	logic [pfm_pkg::CTR_W-1:0]      n_writes = '0;

	result_t pending_results [$];
	int      mismatches = 0;
	bit      steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(15_000_000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned frame_limit();
		if (frames_reg == 0)
			return 1;
		if (frames_reg > pfm_pkg::MAX_FRAMES)
			return pfm_pkg::MAX_FRAMES;
		return frames_reg;
	endfunction

	function automatic bit find_free(output logic [pfm_pkg::FRAME_BITS-1:0] idx);
		int unsigned n;
		n = frame_limit();
		for (int i = 0; i < n; i++)
			if (frame_acc[i] == pfm_pkg::ACC_ABSENT) begin
				idx = pfm_pkg::FRAME_BITS'(i);
				return 1'b1;
			end
		idx = '0;
		return 1'b0;
	endfunction

	// a FIFO eviction from a ring slot never filled would read undefined state
	function automatic bit load_hits_unset();
		logic [pfm_pkg::FRAME_BITS-1:0] idx;
		return !find_free(idx) && policy == pfm_pkg::POLICY_FIFO
			&& ring_head == ring_tail && !ring_loaded[ring_head];
	endfunction

	function automatic result_t predict_fault(fault_t f);
		result_t                        r;
		int unsigned                    n;
		logic [pfm_pkg::FRAME_BITS-1:0] t;
		bit                             ok;
		r = '0;
		ok = 1'b0;
		n = frame_limit();
		n_faults++;
		if (f.access == pfm_pkg::ACC_ABSENT) begin
			if (find_free(t)) begin
				r.status = pfm_pkg::ST_FREE;
				ok = 1'b1;
			end else if (policy == pfm_pkg::POLICY_RANDOM || ring_head == ring_tail) begin
				if (policy == pfm_pkg::POLICY_RANDOM)
					t = pfm_pkg::FRAME_BITS'(f.pick % n);
				else
					t = load_ring[ring_head];
				r.vvalid = 1'b1;
				r.vpage = owner[t];
				if (frame_acc[t][1]) begin   // write bit
					r.vwb = 1'b1;
					n_writes++;
				end
				frame_acc[t] = pfm_pkg::ACC_ABSENT;
				ring_head = pfm_pkg::FRAME_BITS'((ring_head + 1) % n);
				r.status = pfm_pkg::ST_EVICT;
				ok = 1'b1;
			end
			if (ok) begin
				r.access = pfm_pkg::ACC_READ;
				r.fetch = 1'b1;
				n_reads++;
				if (policy == pfm_pkg::POLICY_FIFO) begin
					load_ring[ring_tail] = t;
					ring_loaded[ring_tail] = 1'b1;
					ring_tail = pfm_pkg::FRAME_BITS'((ring_tail + 1) % n);
				end
			end
		end else if (f.access[0] && f.frame < n) begin
			t = f.frame;
			r.access = pfm_pkg::ACC_RW;
			r.status = pfm_pkg::ST_UPGRADE;
			ok = 1'b1;
		end
		if (ok) begin
			owner[t] = f.page;
			frame_acc[t] = r.access;
			r.frame = t;
		end else begin
			r = '0;
			r.status = pfm_pkg::ST_ERROR;
		end
		r.faults = n_faults;
		r.reads = n_reads;
		r.writes = n_writes;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 50)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result transaction", fault_total, 0);
			end else begin
				want = pending_results.pop_front();
				check_field("target_frame", target_frame, want.frame);
				check_field("new_access", new_access, want.access);
				check_field("fault_status", fault_status, want.status);
				check_field("victim_valid", victim_valid, want.vvalid);
				check_field("victim_page", victim_page, want.vpage);
				check_field("victim_writeback", victim_writeback, want.vwb);
				check_field("fetch_from_disk", fetch_from_disk, want.fetch);
				check_field("fault_total", fault_total, want.faults);
				check_field("read_total", read_total, want.reads);
				check_field("write_total", write_total, want.writes);
			end
		end
		out_ready <= steady || ($urandom_range(99) >= 30);
	end

	function automatic logic [15:0] rand16();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic fault_t mk_fault(logic [15:0] page, logic [1:0] access,
			logic [5:0] frame, logic [15:0] pick);
		fault_t f;
		f.page = page;
		f.access = access;
		f.frame = frame;
		f.pick = pick;
		return f;
	endfunction

	function automatic fault_t random_fault(int absent_pct);
		int r;
		fault_t f;
		r = $urandom_range(99);
		if (r < absent_pct)
			f.access = pfm_pkg::ACC_ABSENT;
		else if (r < absent_pct + (100 - absent_pct) * 4 / 10)
			f.access = pfm_pkg::ACC_READ;
		else if (r < 95)
			f.access = pfm_pkg::ACC_RW;
		else
			f.access = pfm_pkg::ACC_INVALID;
		f.page = rand16();
		f.pick = rand16();
		f.frame = pfm_pkg::FRAME_BITS'($urandom);
		return f;
	endfunction

	task automatic send_fault(fault_t f);
		if (f.access == pfm_pkg::ACC_ABSENT && load_hits_unset())
			f.access = pfm_pkg::ACC_INVALID;
		if (!steady && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 120)) @(posedge clk);
		end
		in_valid <= 1'b1;
		fault_page <= f.page;
		entry_access <= f.access;
		entry_frame <= f.frame;
		random_pick <= f.pick;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_fault(f));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(logic pol, logic [pfm_pkg::CFG_W-1:0] frames);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= pfm_pkg::REG_POLICY;
		cfg_data <= {6'($urandom_range(63)), pol};
		@(posedge clk);
		cfg_index <= pfm_pkg::REG_FRAMES;
		cfg_data <= frames;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy = pol;
		frames_reg = frames;
	endtask

	task automatic test_directed();
		send_fault(mk_fault(16'h0000, pfm_pkg::ACC_ABSENT, 6'h00, 16'h0000));
		send_fault(mk_fault(16'hFFFF, pfm_pkg::ACC_ABSENT, 6'h3F, 16'hFFFF));
		send_fault(mk_fault(16'h8001, pfm_pkg::ACC_ABSENT, 6'h2A, 16'h5555));
		send_fault(mk_fault(16'h7FFE, pfm_pkg::ACC_ABSENT, 6'h15, 16'hAAAA));
		send_fault(mk_fault(16'h0000, pfm_pkg::ACC_READ, 6'h00, 16'h0000));
		send_fault(mk_fault(16'hFFFF, pfm_pkg::ACC_RW, 6'h01, 16'hFFFF));
		send_fault(mk_fault(16'h1234, pfm_pkg::ACC_READ, 6'h03, 16'h0F0F));
		send_fault(mk_fault(16'hFFFF, pfm_pkg::ACC_INVALID, 6'h3F, 16'hFFFF));
		send_fault(mk_fault(16'h0000, pfm_pkg::ACC_INVALID, 6'h00, 16'h0000));
		send_fault(mk_fault(16'hABCD, pfm_pkg::ACC_RW, 6'h02, 16'h00FF));
		send_fault(mk_fault(16'h5A5A, pfm_pkg::ACC_RW, 6'h00, 16'hF0F0));
	endtask

	// fill every frame in FIFO order, then run FIFO eviction traffic
	task automatic test_fifo_eviction();
		logic [pfm_pkg::FRAME_BITS-1:0] idx;
		steady = 1'b1;
		while (find_free(idx))
			send_fault(random_fault(100));
		repeat (200) send_fault(random_fault(55));
		steady = 1'b0;
		repeat (200) send_fault(random_fault(55));
	endtask

	task automatic test_random_policy();
		logic [pfm_pkg::CFG_W-1:0] counts [6] = '{7'd1, 7'd0, 7'd37, 7'd127, 7'd100, 7'd2};
		write_cfg(pfm_pkg::POLICY_RANDOM, 7'd64);
		repeat (300) send_fault(random_fault(55));
		foreach (counts[i]) begin
			write_cfg(pfm_pkg::POLICY_RANDOM, counts[i]);
			repeat (60) send_fault(random_fault(55));
		end
	endtask

	// random evictions move the ring head alone, so FIFO loads must fail
	task automatic test_fifo_out_of_step();
		write_cfg(pfm_pkg::POLICY_RANDOM, 7'd64);
		do send_fault(random_fault(100)); while (ring_head == ring_tail);
		write_cfg(pfm_pkg::POLICY_FIFO, 7'd64);
		repeat (24) send_fault(random_fault(80));
	endtask

	task automatic test_fifo_frame_counts();
		logic [pfm_pkg::CFG_W-1:0] counts [6] = '{7'd64, 7'd1, 7'd0, 7'd5, 7'd127, 7'd33};
		write_cfg(pfm_pkg::POLICY_RANDOM, 7'd64);
		while (ring_head != ring_tail)
			send_fault(random_fault(100));
		foreach (counts[i]) begin
			write_cfg(pfm_pkg::POLICY_FIFO, counts[i]);
			repeat (80) send_fault(random_fault(60));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fifo_eviction();
		test_random_policy();
		test_fifo_out_of_step();
		test_fifo_frame_counts();
		drain();
		repeat (150) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
